>>> hw/rtl/bmf_pkg.sv
// ============================================================================
// bmf_pkg
// Shared constants and types of the binary morphology filter: kernel geometry,
// line-store word layout, register indexes and the records that travel
// between the pipeline stages.
// ============================================================================
package bmf_pkg;

	// Structuring element geometry (square, centered).
	localparam int KERNEL     = 5;
	localparam int HALF       = KERNEL / 2;
	localparam int KMASK_W    = KERNEL * KERNEL;

	// The line store keeps enough rows that the row being written never
	// lands on a row the window still reads.
	localparam int STORE_ROWS = 3 * HALF + 1;
	localparam int SLOT_W     = $clog2(STORE_ROWS);

	// Two-bit pixel code: one bit for "equals full", one for "equals empty".
	localparam int CODE_W     = 2;
	localparam int CODE_FULL  = 0;
	localparam int CODE_EMPTY = 1;

	// Pixel values.
	localparam int PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_FULL  = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_EMPTY = 8'h00;

	// Register file.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 25;
	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam logic [KMASK_W-1:0] KMASK_RESET = 25'd473536;
	localparam logic [FW_W-1:0]    FW_RESET    = 11'd640;
	localparam logic [FH_W-1:0]    FH_RESET    = 13'd480;

	// Row counters: output row stays below the height, input row may run a
	// few rows past it while the frame drains.
	localparam int ROW_W  = FH_W;
	localparam int IROW_W = FH_W + 1;

	// Output queue.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MORPH_OP,
		REG_KERNEL_MASK,
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} bmf_reg_t;

	typedef enum logic {
		OP_DILATE,
		OP_ERODE
	} bmf_op_t;

	// One line-store word: the codes of every stored row at one column.
	typedef logic [STORE_ROWS-1:0][CODE_W-1:0] bmf_word_t;

	// Per-request control record, decided when the request is taken.
	typedef struct packed {
		logic               wr;
		logic [CODE_W-1:0]  code;
		logic [SLOT_W-1:0]  wr_slot;
		logic               res;
		logic               last;
		bmf_op_t            op;
		logic [SLOT_W-1:0]  out_slot;
		logic [KMASK_W-1:0] mask;
	} bmf_step_t;

	// One result.
	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] pixel;
	} bmf_result_t;

endpackage

>>> hw/rtl/bmf_ctrl.sv
// ============================================================================
// bmf_ctrl
// Register file and raster position tracking. For each request it decides
// whether the pixel is stored, whether a result leaves, whether that result
// ends the frame, and which window cells count for it.
// ============================================================================
module bmf_ctrl #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bmf_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            accept,
	input  logic [bmf_pkg::PIX_W-1:0]       pixel,
	input  logic                            drain,
	output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
	output bmf_pkg::bmf_step_t              step
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = (WW > bmf_pkg::FW_W) ? WW : bmf_pkg::FW_W;
	localparam int POS_W = CMP_W + 2;
	localparam int RX_W  = bmf_pkg::ROW_W + 2;

	bmf_pkg::bmf_op_t                  op_q;
	logic [bmf_pkg::KMASK_W-1:0]       kmask_q;
	logic [bmf_pkg::FW_W-1:0]          fw_q;
	logic [bmf_pkg::FH_W-1:0]          fh_q;

	logic [COL_W-1:0]                  in_col_q, in_col_n;
	logic [bmf_pkg::IROW_W-1:0]        in_row_q, in_row_n;
	logic [bmf_pkg::SLOT_W-1:0]        in_slot_q, in_slot_n;
	logic [COL_W-1:0]                  out_col_q, out_col_n;
	logic [bmf_pkg::ROW_W-1:0]         out_row_q, out_row_n;
	logic [bmf_pkg::SLOT_W-1:0]        out_slot_q, out_slot_n;

	logic [CMP_W-1:0]                  w;
	logic [bmf_pkg::FH_W-1:0]          h;
	logic [POS_W-1:0]                  w_p, col_p;
	logic                              past_lag;
	logic                              last_c;
	logic [bmf_pkg::KERNEL-1:0]        rv, cv;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= bmf_pkg::OP_DILATE;
			kmask_q <= bmf_pkg::KMASK_RESET;
			fw_q    <= bmf_pkg::FW_RESET;
			fh_q    <= bmf_pkg::FH_RESET;
		end else if (cfg_we) begin
			unique case (bmf_pkg::bmf_reg_t'(cfg_index))
				bmf_pkg::REG_MORPH_OP:     op_q    <= bmf_pkg::bmf_op_t'(cfg_data[0]);
				bmf_pkg::REG_KERNEL_MASK:  kmask_q <= cfg_data[bmf_pkg::KMASK_W-1:0];
				bmf_pkg::REG_FRAME_WIDTH:  fw_q    <= cfg_data[bmf_pkg::FW_W-1:0];
				bmf_pkg::REG_FRAME_HEIGHT: fh_q    <= cfg_data[bmf_pkg::FH_W-1:0];
			endcase
		end
	end

	// Effective frame size: zero acts as one, width is capped by the store.
	always_comb begin
		priority if (fw_q == '0) begin
			w = CMP_W'(1);
		end else if (CMP_W'(fw_q) > CMP_W'(MAX_WIDTH)) begin
			w = CMP_W'(MAX_WIDTH);
		end else begin
			w = CMP_W'(fw_q);
		end
		h = (fh_q == '0) ? bmf_pkg::FH_W'(1) : fh_q;
	end

	// Has the input run far enough ahead (HALF rows plus HALF pixels) for a
	// result to leave? The row-by-row split avoids a multiply; it is written
	// for a half size of two.
	always_comb begin
		w_p   = POS_W'(w);
		col_p = POS_W'(in_col_q);
		priority if (in_row_q == bmf_pkg::IROW_W'(0)) begin
			past_lag = col_p >= ((w_p << 1) + POS_W'(bmf_pkg::HALF));
		end else if (in_row_q == bmf_pkg::IROW_W'(1)) begin
			past_lag = col_p >= (w_p + POS_W'(bmf_pkg::HALF));
		end else if (in_row_q == bmf_pkg::IROW_W'(bmf_pkg::HALF)) begin
			past_lag = col_p >= POS_W'(bmf_pkg::HALF);
		end else if (in_row_q == bmf_pkg::IROW_W'(bmf_pkg::HALF + 1)) begin
			past_lag = (w >= CMP_W'(2)) || (col_p >= POS_W'(1));
		end else begin
			past_lag = 1'b1;
		end
	end

	// The result at or past the last row and column ends the frame.
	assign last_c = (out_row_q >= (h - bmf_pkg::FH_W'(1)))
		&& (CMP_W'(out_col_q) >= (w - CMP_W'(1)));

	// In-frame tests for each window row and column around the output pixel.
	always_comb begin
		logic [RX_W-1:0]  r_t;
		logic [POS_W-1:0] c_t;
		for (int i = 0; i < bmf_pkg::KERNEL; i++) begin
			r_t   = RX_W'(out_row_q) + RX_W'(i) - RX_W'(bmf_pkg::HALF);
			rv[i] = !r_t[RX_W-1] && (r_t < RX_W'(h));
			c_t   = POS_W'(out_col_q) + POS_W'(i) - POS_W'(bmf_pkg::HALF);
			cv[i] = !c_t[POS_W-1] && (c_t < w_p);
		end
	end

	// Control record for this request.
	always_comb begin
		step.wr       = !drain && (bmf_pkg::IROW_W'(h) > in_row_q);
		step.code[bmf_pkg::CODE_FULL]  = (pixel == bmf_pkg::PIX_FULL);
		step.code[bmf_pkg::CODE_EMPTY] = (pixel == bmf_pkg::PIX_EMPTY);
		step.wr_slot  = in_slot_q;
		step.res      = past_lag;
		step.last     = past_lag && last_c;
		step.op       = op_q;
		step.out_slot = out_slot_q;
		for (int i = 0; i < bmf_pkg::KERNEL; i++) begin
			for (int j = 0; j < bmf_pkg::KERNEL; j++) begin
				step.mask[i*bmf_pkg::KERNEL + j] =
					kmask_q[i*bmf_pkg::KERNEL + j] & rv[i] & cv[j];
			end
		end
	end

	assign rd_addr = in_col_q;

	// Next raster positions.
	always_comb begin
		logic [CMP_W-1:0] in_inc;
		logic [CMP_W-1:0] out_inc;
		in_inc  = CMP_W'(in_col_q) + CMP_W'(1);
		out_inc = CMP_W'(out_col_q) + CMP_W'(1);

		in_col_n   = in_col_q;
		in_row_n   = in_row_q;
		in_slot_n  = in_slot_q;
		out_col_n  = out_col_q;
		out_row_n  = out_row_q;
		out_slot_n = out_slot_q;

		if (in_inc >= w) begin
			in_col_n  = '0;
			in_row_n  = in_row_q + bmf_pkg::IROW_W'(1);
			in_slot_n = (in_slot_q == bmf_pkg::SLOT_W'(bmf_pkg::STORE_ROWS - 1))
				? '0 : in_slot_q + bmf_pkg::SLOT_W'(1);
		end else begin
			in_col_n = COL_W'(in_inc);
		end

		if (past_lag) begin
			if (last_c) begin
				// End of frame: everything starts over.
				in_col_n   = '0;
				in_row_n   = '0;
				in_slot_n  = '0;
				out_col_n  = '0;
				out_row_n  = '0;
				out_slot_n = '0;
			end else if (out_inc >= w) begin
				out_col_n  = '0;
				out_row_n  = out_row_q + bmf_pkg::ROW_W'(1);
				out_slot_n = (out_slot_q == bmf_pkg::SLOT_W'(bmf_pkg::STORE_ROWS - 1))
					? '0 : out_slot_q + bmf_pkg::SLOT_W'(1);
			end else begin
				out_col_n = COL_W'(out_inc);
			end
		end
	end

	// Position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else if (accept) begin
			in_col_q   <= in_col_n;
			in_row_q   <= in_row_n;
			in_slot_q  <= in_slot_n;
			out_col_q  <= out_col_n;
			out_row_q  <= out_row_n;
			out_slot_q <= out_slot_n;
		end
	end

endmodule

>>> hw/rtl/bmf_line_mem.sv
// ============================================================================
// bmf_line_mem
// Column-organized line store. Each word holds the codes of all stored rows
// at one column. A request reads the word at the input column, merges the
// new pixel code into its row slot in the next cycle and writes it back; the
// merged word also feeds the window.
// ============================================================================
module bmf_line_mem #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [$clog2(MAX_WIDTH)-1:0]  req_addr,
	input  bmf_pkg::bmf_step_t            req_step,
	output logic                          col_valid,
	output bmf_pkg::bmf_word_t            col_word,
	output bmf_pkg::bmf_step_t            col_step
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	bmf_pkg::bmf_word_t   mem_q [MAX_WIDTH];

	bmf_pkg::bmf_word_t   rd_word_s1;
	logic [COL_W-1:0]     addr_s1;
	bmf_pkg::bmf_step_t   step_s1;
	logic                 valid_s1;

	logic                 wb_valid_q;
	logic [COL_W-1:0]     wb_addr_q;
	bmf_pkg::bmf_word_t   wb_word_q;

	bmf_pkg::bmf_word_t   base_word;
	bmf_pkg::bmf_word_t   merged;
	logic                 wr_en;

	// The previous write may land on the same edge as this read; take it
	// from the write-back register when the columns match.
	always_comb begin
		base_word = (wb_valid_q && (wb_addr_q == addr_s1)) ? wb_word_q : rd_word_s1;
		merged    = base_word;
		if (step_s1.wr) begin
			merged[step_s1.wr_slot] = step_s1.code;
		end
	end

	assign wr_en = valid_s1 && step_s1.wr;

	// Memory read and write-back, plus the stage-one payload.
	always_ff @(posedge clk) begin
		if (req_valid) begin
			rd_word_s1 <= mem_q[req_addr];
			addr_s1    <= req_addr;
			step_s1    <= req_step;
		end
		if (wr_en) begin
			mem_q[addr_s1] <= merged;
			wb_addr_q      <= addr_s1;
			wb_word_q      <= merged;
		end
	end

	// Stage valid and write-back valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wb_valid_q <= 1'b0;
		end else begin
			valid_s1 <= req_valid;
			if (wr_en) begin
				wb_valid_q <= 1'b1;
			end
		end
	end

	assign col_valid = valid_s1;
	assign col_word  = merged;
	assign col_step  = step_s1;

endmodule

>>> hw/rtl/bmf_window.sv
// ============================================================================
// bmf_window
// Sliding window of line-store words, one per column. Each request shifts
// in one column; the result is the masked match over the window rows that
// sit around the output row.
// ============================================================================
module bmf_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  col_valid,
	input  bmf_pkg::bmf_word_t    col_word,
	input  bmf_pkg::bmf_step_t    col_step,
	output logic                  res_valid,
	output bmf_pkg::bmf_result_t  res,
	output logic                  busy
);

	localparam int SUM_W = bmf_pkg::SLOT_W + 1;

	bmf_pkg::bmf_word_t  win_q [bmf_pkg::KERNEL];
	bmf_pkg::bmf_step_t  step_s2;
	logic                valid_s2;
	logic                hit;
	logic                want;

	// Store slot of window row i, counted from the top of the window.
	function automatic logic [bmf_pkg::SLOT_W-1:0] row_slot(
		input logic [bmf_pkg::SLOT_W-1:0] base,
		input int                         i
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(i + bmf_pkg::STORE_ROWS - bmf_pkg::HALF);
		priority if (sum >= SUM_W'(2 * bmf_pkg::STORE_ROWS)) begin
			sum = sum - SUM_W'(2 * bmf_pkg::STORE_ROWS);
		end else if (sum >= SUM_W'(bmf_pkg::STORE_ROWS)) begin
			sum = sum - SUM_W'(bmf_pkg::STORE_ROWS);
		end
		return sum[bmf_pkg::SLOT_W-1:0];
	endfunction

	// Column shift; the newest column is the right edge of the window.
	always_ff @(posedge clk) begin
		if (col_valid) begin
			for (int j = 0; j < bmf_pkg::KERNEL - 1; j++) begin
				win_q[j] <= win_q[j+1];
			end
			win_q[bmf_pkg::KERNEL-1] <= col_word;
			step_s2 <= col_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= col_valid;
		end
	end

	// Dilation looks for a full neighbor, erosion for an empty one.
	always_comb begin
		logic [bmf_pkg::SLOT_W-1:0] s;
		want = (step_s2.op == bmf_pkg::OP_ERODE) ? 1'(bmf_pkg::CODE_EMPTY)
			: 1'(bmf_pkg::CODE_FULL);
		hit  = 1'b0;
		for (int i = 0; i < bmf_pkg::KERNEL; i++) begin
			s = row_slot(step_s2.out_slot, i);
			for (int j = 0; j < bmf_pkg::KERNEL; j++) begin
				hit = hit | (step_s2.mask[i*bmf_pkg::KERNEL + j] & win_q[j][s][want]);
			end
		end
	end

	// A hit gives full for dilation and empty for erosion.
	assign res_valid = valid_s2 && step_s2.res;
	assign res.pixel = (hit ^ (step_s2.op == bmf_pkg::OP_ERODE))
		? bmf_pkg::PIX_FULL : bmf_pkg::PIX_EMPTY;
	assign res.last  = step_s2.last;
	assign busy      = valid_s2;

endmodule

>>> hw/rtl/bmf_out_queue.sv
// ============================================================================
// bmf_out_queue
// Small result queue between the pipeline and the output stream. It absorbs
// every result already in flight when the output stalls.
// ============================================================================
module bmf_out_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  bmf_pkg::bmf_result_t            push_data,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output bmf_pkg::bmf_result_t            pop_data,
	output logic [bmf_pkg::OQ_LVL_W-1:0]    level
);

	bmf_pkg::bmf_result_t            q_q [bmf_pkg::OQ_DEPTH];
	logic [bmf_pkg::OQ_PTR_W-1:0]    wr_ptr_q;
	logic [bmf_pkg::OQ_PTR_W-1:0]    rd_ptr_q;
	logic [bmf_pkg::OQ_LVL_W-1:0]    level_q;
	logic                            pop;

	assign m_tvalid = (level_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign pop_data = q_q[rd_ptr_q];
	assign level    = level_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bmf_pkg::OQ_PTR_W'(bmf_pkg::OQ_DEPTH - 1))
					? '0 : wr_ptr_q + bmf_pkg::OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bmf_pkg::OQ_PTR_W'(bmf_pkg::OQ_DEPTH - 1))
					? '0 : rd_ptr_q + bmf_pkg::OQ_PTR_W'(1);
			end
			level_q <= level_q + bmf_pkg::OQ_LVL_W'(push) - bmf_pkg::OQ_LVL_W'(pop);
		end
	end

endmodule

>>> hw/rtl/binary_morphology_filter.sv
// ============================================================================
// binary_morphology_filter
// Binary dilation or erosion over a raster pixel stream with a centered 5x5
// structuring element, backed by a column-organized line store.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   s_tdata = pixel_in, s_tuser = drain
//   m_*       out        m_tvalid/m_tready   m_tdata = pixel_out, m_tlast = last_of_frame
//   cfg_*     in         cfg_we              cfg_index, cfg_data
//
// One request per clock while s_tready is high. The line store is read at
// the input column and written back the next cycle, one column per cycle;
// a write-back register covers a read that meets the previous write. Results
// pass the line-store and window stages, then the result queue. s_tready
// drops only when the four-entry result queue plus the two pipeline stages
// would overflow. Reset clears counters and presets registers; the line
// store is not cleared and each entry is defined once the frame writes it.
// ============================================================================
module binary_morphology_filter #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] pixel_in
	input  logic                           s_tuser,   // [0] drain

	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] pixel_out
	output logic                           m_tlast,

	input  logic                           cfg_we,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmf_pkg::CFG_W-1:0]      cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                           accept;
	logic [COL_W-1:0]               rd_addr;
	bmf_pkg::bmf_step_t             step;
	logic                           col_valid;
	bmf_pkg::bmf_word_t             col_word;
	bmf_pkg::bmf_step_t             col_step;
	logic                           res_valid;
	bmf_pkg::bmf_result_t           res;
	logic                           busy;
	bmf_pkg::bmf_result_t           out_data;
	logic [bmf_pkg::OQ_LVL_W-1:0]   level;

	// Take a request only if every result in flight still finds room.
	assign s_tready = (level + bmf_pkg::OQ_LVL_W'(col_valid) + bmf_pkg::OQ_LVL_W'(busy))
		< bmf_pkg::OQ_LVL_W'(bmf_pkg::OQ_DEPTH);
	assign accept   = s_tvalid && s_tready;

	bmf_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.pixel     (s_tdata),
		.drain     (s_tuser),
		.rd_addr   (rd_addr),
		.step      (step)
	);

	bmf_line_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (accept),
		.req_addr  (rd_addr),
		.req_step  (step),
		.col_valid (col_valid),
		.col_word  (col_word),
		.col_step  (col_step)
	);

	bmf_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (col_valid),
		.col_word  (col_word),
		.col_step  (col_step),
		.res_valid (res_valid),
		.res       (res),
		.busy      (busy)
	);

	bmf_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.pop_data  (out_data),
		.level     (level)
	);

	assign m_tdata = out_data.pixel;
	assign m_tlast = out_data.last;

endmodule
